>>> rtl/core/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

	// parse phases
	localparam logic [2:0] PH_COLON  = 3'd0;
	localparam logic [2:0] PH_LEN    = 3'd1;
	localparam logic [2:0] PH_OFFSET = 3'd2;
	localparam logic [2:0] PH_TYPE   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_UPPER  = 3'd5;
	localparam logic [2:0] PH_CHECK  = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_EOF    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_COLON = 3'd1;
	localparam logic [2:0] ERR_HEX   = 3'd2;
	localparam logic [2:0] ERR_TYPE  = 3'd3;
	localparam logic [2:0] ERR_SUM   = 3'd4;

	// record types
	localparam logic [7:0] REC_DATA  = 8'h00;
	localparam logic [7:0] REC_EOF   = 8'h01;
	localparam logic [7:0] REC_UPPER = 8'h04;

	localparam logic [7:0] CHAR_COLON = 8'h3a;

	typedef struct packed {
		logic       is_space;
		logic       is_colon;
		logic       is_hex;
		logic [3:0] nibble;
	} char_class_t;

endpackage

`default_nettype wire

>>> rtl/core/ihex_char_if.sv
`default_nettype none

interface ihex_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ihex_result_if.sv
`default_nettype none

interface ihex_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] address;
	logic [7:0]  data_byte;
	logic [2:0]  error_code;

	modport source (output valid, output kind, output address, output data_byte,
		output error_code, input ready);
	modport sink (input valid, input kind, input address, input data_byte,
		input error_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ihex_char_decode.sv
`default_nettype none

module ihex_char_decode (
	input  wire logic [7:0]           char_in,
	output ihex_pkg::char_class_t     cls
);

	always_comb begin
		cls.is_space = (char_in == 8'h20) || ((char_in >= 8'h09) && (char_in <= 8'h0d));
		cls.is_colon = (char_in == ihex_pkg::CHAR_COLON);
		cls.is_hex   = 1'b1;
		cls.nibble   = 4'd0;
		priority if ((char_in >= 8'h30) && (char_in <= 8'h39)) begin
			cls.nibble = 4'(char_in - 8'h30);
		end else if ((char_in >= 8'h41) && (char_in <= 8'h46)) begin
			cls.nibble = 4'(char_in - 8'h37);
		end else if ((char_in >= 8'h61) && (char_in <= 8'h66)) begin
			cls.nibble = 4'(char_in - 8'h57);
		end else begin
			cls.is_hex = 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/intel_hex_record_parser.sv
`default_nettype none

// Intel HEX record parser. One ASCII character is taken per beat on chars and
// whitespace is skipped anywhere. Each data byte of a type 00 record comes out
// on records as a data beat with its 32-bit address ((upper << 16) + offset +
// position); a type 04 record loads the upper address from its first two
// payload bytes, a type 01 record gives end of file at once and a good check
// byte gives record accepted. A missing colon, a bad hex digit, an unknown
// type or a checksum mismatch gives an error beat; after an error or end of
// file all characters are swallowed until reset. The parse state is updated in
// the cycle the beat is taken and the result sits in a single output register,
// so a character is taken in every cycle while that register is empty or being
// drained. Most characters give no result beat at all.

module intel_hex_record_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ihex_char_if.sink       chars,
	ihex_result_if.source   records
);

	// character classification
	ihex_pkg::char_class_t cls;

	ihex_char_decode u_decode (
		.char_in (chars.char_in),
		.cls     (cls)
	);

	// parse state
	logic [2:0]  phase_q,       phase_d;
	logic        lnp_q,         lnp_d;
	logic [3:0]  accum_q,       accum_d;
	logic        fbi_q,         fbi_d;
	logic [7:0]  length_q,      length_d;
	logic [7:0]  remaining_q,   remaining_d;
	logic [15:0] offset_q,      offset_d;
	logic [15:0] upper_q,       upper_d;
	logic [7:0]  sum_q,         sum_d;
	logic [31:0] addr_q,        addr_d;
	logic        halted_q,      halted_d;

	// result of this beat
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [31:0] res_addr;
	logic [7:0]  res_data;
	logic [2:0]  res_err;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_addr_q;
	logic [7:0]  out_data_q;
	logic [2:0]  out_err_q;

	logic        in_fire;
	logic [7:0]  byte_val;
	logic [15:0] offset_next;
	logic [7:0]  remaining_next;

	assign chars.ready = !out_valid_q || records.ready;
	assign in_fire     = chars.valid && chars.ready;

	assign byte_val       = {accum_q, cls.nibble};
	assign offset_next    = {offset_q[7:0], byte_val};
	assign remaining_next = remaining_q - 8'd1;

	always_comb begin
		phase_d     = phase_q;
		lnp_d       = lnp_q;
		accum_d     = accum_q;
		fbi_d       = fbi_q;
		length_d    = length_q;
		remaining_d = remaining_q;
		offset_d    = offset_q;
		upper_d     = upper_q;
		sum_d       = sum_q;
		addr_d      = addr_q;
		halted_d    = halted_q;
		res_valid   = 1'b0;
		res_kind    = ihex_pkg::KIND_DATA;
		res_addr    = 32'd0;
		res_data    = 8'd0;
		res_err     = ihex_pkg::ERR_NONE;

		if (!halted_q && !cls.is_space) begin
			if (phase_q == ihex_pkg::PH_COLON) begin
				if (!cls.is_colon) begin
					halted_d  = 1'b1;
					res_valid = 1'b1;
					res_kind  = ihex_pkg::KIND_ERROR;
					res_err   = ihex_pkg::ERR_COLON;
				end else begin
					sum_d    = 8'd0;
					lnp_d    = 1'b0;
					fbi_d    = 1'b0;
					offset_d = 16'd0;
					phase_d  = ihex_pkg::PH_LEN;
				end
			end else if (!cls.is_hex) begin
				halted_d  = 1'b1;
				res_valid = 1'b1;
				res_kind  = ihex_pkg::KIND_ERROR;
				res_err   = ihex_pkg::ERR_HEX;
			end else if (!lnp_q) begin
				accum_d = cls.nibble;
				lnp_d   = 1'b1;
			end else begin
				lnp_d = 1'b0;
				// running sum holds minus the bytes so far, check byte excluded
				if (phase_q != ihex_pkg::PH_CHECK) begin
					sum_d = sum_q - byte_val;
				end
				unique case (phase_q)
					ihex_pkg::PH_LEN: begin
						length_d = byte_val;
						phase_d  = ihex_pkg::PH_OFFSET;
						fbi_d    = 1'b0;
					end
					ihex_pkg::PH_OFFSET: begin
						offset_d = offset_next;
						if (!fbi_q) begin
							fbi_d = 1'b1;
						end else begin
							fbi_d   = 1'b0;
							addr_d  = {upper_q, 16'd0} + {16'd0, offset_next};
							phase_d = ihex_pkg::PH_TYPE;
						end
					end
					ihex_pkg::PH_TYPE: begin
						priority if (byte_val == ihex_pkg::REC_DATA) begin
							remaining_d = length_q;
							phase_d     = (length_q == 8'd0) ? ihex_pkg::PH_CHECK
								: ihex_pkg::PH_DATA;
						end else if (byte_val == ihex_pkg::REC_EOF) begin
							halted_d  = 1'b1;
							res_valid = 1'b1;
							res_kind  = ihex_pkg::KIND_EOF;
						end else if (byte_val == ihex_pkg::REC_UPPER) begin
							fbi_d   = 1'b0;
							phase_d = ihex_pkg::PH_UPPER;
						end else begin
							halted_d  = 1'b1;
							res_valid = 1'b1;
							res_kind  = ihex_pkg::KIND_ERROR;
							res_err   = ihex_pkg::ERR_TYPE;
						end
					end
					ihex_pkg::PH_DATA: begin
						addr_d      = addr_q + 32'd1;
						remaining_d = remaining_next;
						if (remaining_next == 8'd0) begin
							phase_d = ihex_pkg::PH_CHECK;
						end
						res_valid = 1'b1;
						res_kind  = ihex_pkg::KIND_DATA;
						res_addr  = addr_q;
						res_data  = byte_val;
					end
					ihex_pkg::PH_UPPER: begin
						// upper address is loaded from exactly two bytes
						if (!fbi_q) begin
							upper_d = {byte_val, 8'd0};
							fbi_d   = 1'b1;
						end else begin
							upper_d = {upper_q[15:8], byte_val};
							fbi_d   = 1'b0;
							phase_d = ihex_pkg::PH_CHECK;
						end
					end
					default: begin
						// check byte, and any unused phase code behaves the same
						phase_d   = ihex_pkg::PH_COLON;
						res_valid = 1'b1;
						if (byte_val != sum_q) begin
							halted_d = 1'b1;
							res_kind = ihex_pkg::KIND_ERROR;
							res_err  = ihex_pkg::ERR_SUM;
						end else begin
							res_kind = ihex_pkg::KIND_ACCEPT;
						end
					end
				endcase
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ihex_pkg::PH_COLON;
			lnp_q       <= 1'b0;
			accum_q     <= 4'd0;
			fbi_q       <= 1'b0;
			length_q    <= 8'd0;
			remaining_q <= 8'd0;
			offset_q    <= 16'd0;
			upper_q     <= 16'd0;
			sum_q       <= 8'd0;
			addr_q      <= 32'd0;
			halted_q    <= 1'b0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			lnp_q       <= lnp_d;
			accum_q     <= accum_d;
			fbi_q       <= fbi_d;
			length_q    <= length_d;
			remaining_q <= remaining_d;
			offset_q    <= offset_d;
			upper_q     <= upper_d;
			sum_q       <= sum_d;
			addr_q      <= addr_d;
			halted_q    <= halted_d;
		end
	end

	// output register: refilled on every taken character, drained by ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res_valid;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			out_kind_q <= res_kind;
			out_addr_q <= res_addr;
			out_data_q <= res_data;
			out_err_q  <= res_err;
		end
	end

	assign records.valid      = out_valid_q;
	assign records.kind       = out_kind_q;
	assign records.address    = out_addr_q;
	assign records.data_byte  = out_data_q;
	assign records.error_code = out_err_q;

	// once halted, only reset leaves that state
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("parser left the halted state");

	// a halted parser swallows characters without producing beats
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && in_fire) |=> !records.valid)
		else $error("beat produced while halted");

	// the data phase is never entered with nothing left to read
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ihex_pkg::PH_DATA) |-> (remaining_q != 8'd0))
		else $error("data phase with zero bytes remaining");

	// an error beat always carries a code, other beats never do
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid |-> ((records.kind == ihex_pkg::KIND_ERROR)
			== (records.error_code != ihex_pkg::ERR_NONE)))
		else $error("error code does not match result kind");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import ihex_pkg::*;

	localparam int CHAR_TARGET = 1000;  // characters, blanks included, in the random part
	localparam int CALM_FROM   = 850;   // no idling on either side past this point
	localparam int STALL_LIMIT = 2000;  // cycles without any beat before giving up
	localparam int TAIL_CYCLES = 10;    // settling time once nothing is outstanding

	// one beat on the records channel
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [7:0]  data_byte;
		logic [2:0]  error_code;
	} rec_beat_t;

	// tracks the parser state from the characters taken and holds the beats still due
	class record_tracker;
		logic [2:0]  phase = PH_COLON;
		bit          nib_pending = 1'b0;
		logic [3:0]  hi_nibble = '0;
		bit          field_idx = 1'b0;
		logic [7:0]  rec_len = '0;
		logic [7:0]  remaining = '0;
		logic [15:0] offset = '0;
		logic [15:0] upper = '0;
		logic [7:0]  csum = '0;
		logic [31:0] next_addr = '0;
		bit          halted = 1'b0;
		rec_beat_t   beats_due [$];
		int unsigned fails = 0;

		static function bit is_blank(logic [7:0] c);
			return c == " " || (c >= 8'h09 && c <= 8'h0d);
		endfunction

		static function bit is_hex(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
		endfunction

		function int pending();
			return beats_due.size();
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			fails++;
		endtask

		task push_beat(logic [1:0] kind, logic [31:0] addr, logic [7:0] data,
				logic [2:0] err);
			rec_beat_t b;
			b.kind = kind;
			b.address = addr;
			b.data_byte = data;
			b.error_code = err;
			beats_due.push_back(b);
		endtask

		task abort(logic [2:0] err);
			halted = 1'b1;
			push_beat(KIND_ERROR, '0, '0, err);
		endtask

		task take_byte(logic [7:0] b);
			if (phase != PH_CHECK)
				csum = csum - b;
			case (phase)
				PH_LEN: begin
					rec_len = b;
					field_idx = 1'b0;
					phase = PH_OFFSET;
				end
				PH_OFFSET: begin
					offset = {offset[7:0], b};
					if (!field_idx) begin
						field_idx = 1'b1;
					end else begin
						field_idx = 1'b0;
						next_addr = {upper, 16'h0000} + {16'h0000, offset};
						phase = PH_TYPE;
					end
				end
				PH_TYPE: begin
					if (b == REC_DATA) begin
						remaining = rec_len;
						phase = (rec_len == 8'h00) ? PH_CHECK : PH_DATA;
					end else if (b == REC_EOF) begin
						halted = 1'b1;
						push_beat(KIND_EOF, '0, '0, ERR_NONE);
					end else if (b == REC_UPPER) begin
						field_idx = 1'b0;
						phase = PH_UPPER;
					end else begin
						abort(ERR_TYPE);
					end
				end
				PH_DATA: begin
					push_beat(KIND_DATA, next_addr, b, ERR_NONE);
					next_addr = next_addr + 32'd1;
					remaining = remaining - 8'd1;
					if (remaining == 8'h00)
						phase = PH_CHECK;
				end
				PH_UPPER: begin
					if (!field_idx) begin
						upper = {b, 8'h00};
						field_idx = 1'b1;
					end else begin
						upper[7:0] = b;
						field_idx = 1'b0;
						phase = PH_CHECK;
					end
				end
				default: begin
					phase = PH_COLON;
					if (b != csum)
						abort(ERR_SUM);
					else
						push_beat(KIND_ACCEPT, '0, '0, ERR_NONE);
				end
			endcase
		endtask

		task note_char(logic [7:0] c);
			logic [3:0] nib;
			if (halted || is_blank(c))
				return;
			if (phase == PH_COLON) begin
				if (c != CHAR_COLON) begin
					abort(ERR_COLON);
					return;
				end
				csum = '0;
				nib_pending = 1'b0;
				field_idx = 1'b0;
				offset = '0;
				phase = PH_LEN;
				return;
			end
			if (!is_hex(c)) begin
				abort(ERR_HEX);
				return;
			end
			// digits carry their value in the low nibble, letters are off by nine
			nib = (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
			if (!nib_pending) begin
				hi_nibble = nib;
				nib_pending = 1'b1;
			end else begin
				nib_pending = 1'b0;
				take_byte({hi_nibble, nib});
			end
		endtask

		task check_beat(rec_beat_t got);
			rec_beat_t want;
			if (beats_due.size() == 0) begin
				report($sformatf("beat with none due: kind %0d address %h data %h error %0d",
					got.kind, got.address, got.data_byte, got.error_code));
				return;
			end
			want = beats_due.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
			if (got.address !== want.address)
				report($sformatf("address %h, wanted %h", got.address, want.address));
			if (got.data_byte !== want.data_byte)
				report($sformatf("data_byte %h, wanted %h", got.data_byte, want.data_byte));
			if (got.error_code !== want.error_code)
				report($sformatf("error_code %0d, wanted %0d", got.error_code, want.error_code));
		endtask

		task close();
			if (beats_due.size() != 0)
				report($sformatf("%0d beats never arrived", beats_due.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;

	ihex_char_if   chars_if ();
	ihex_result_if records_if ();

	intel_hex_record_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.records (records_if)
	);

	record_tracker tracker;
	bit            idling;
	int            chars_sent;
	int            stall_left = 0;
	logic [7:0]    payload_q [$];
	rec_beat_t     seen_beat;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// beats are taken at the rising edge; the result beat is checked before the
	// character of the same edge is noted, as a character's beat passes the output register
	always @(posedge clk) begin
		if (records_if.valid && records_if.ready) begin
			seen_beat.kind = records_if.kind;
			seen_beat.address = records_if.address;
			seen_beat.data_byte = records_if.data_byte;
			seen_beat.error_code = records_if.error_code;
			tracker.check_beat(seen_beat);
		end
		if (chars_if.valid && chars_if.ready)
			tracker.note_char(chars_if.char_in);
	end

	// receiver back-pressure: random bursts with ready low while idling is set
	always @(negedge clk) begin
		if (!arst_n) begin
			records_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			records_if.ready <= 1'b0;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 10);
			records_if.ready <= 1'b0;
		end else begin
			records_if.ready <= 1'b1;
		end
	end

	// watchdog: give up after too long without a beat on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((chars_if.valid && chars_if.ready) || (records_if.valid && records_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 4'd10)
			return "0" + n;
		return (lower ? "a" : "A") + n - 8'd10;
	endfunction

	function automatic logic [7:0] blank_char();
		logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
		return blanks[$urandom_range(0, 5)];
	endfunction

	// one character beat; entered and left at a falling edge
	task automatic send_char(logic [7:0] c);
		if (idling && $urandom_range(0, 7) == 0) begin
			chars_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_in <= c;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		chars_sent++;
		@(negedge clk);
	endtask

	// two hex digits in random case, with the odd stray blank before or between them
	task automatic send_byte(logic [7:0] b);
		if ($urandom_range(0, 9) == 0)
			send_char(blank_char());
		send_char(hex_char(b[7:4], 1'($urandom_range(0, 1))));
		if ($urandom_range(0, 9) == 0)
			send_char(blank_char());
		send_char(hex_char(b[3:0], 1'($urandom_range(0, 1))));
	endtask

	// a whole record with its payload taken from payload_q; sum_flip spoils the check byte
	task automatic send_record(logic [7:0] len_field, logic [15:0] offset,
			logic [7:0] rec_type, logic [7:0] sum_flip);
		logic [7:0] sum;
		sum = len_field + offset[15:8] + offset[7:0] + rec_type;
		foreach (payload_q[i])
			sum = sum + payload_q[i];
		if ($urandom_range(0, 3) == 0)
			send_char(blank_char());
		send_char(CHAR_COLON);
		send_byte(len_field);
		send_byte(offset[15:8]);
		send_byte(offset[7:0]);
		send_byte(rec_type);
		foreach (payload_q[i])
			send_byte(payload_q[i]);
		send_byte((8'h00 - sum) ^ sum_flip);
		if ($urandom_range(0, 1) == 0)
			send_char(8'h0d);
		send_char(8'h0a);
	endtask

	task automatic fill_payload(int count);
		payload_q.delete();
		repeat (count)
			payload_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// sender holds off until every beat due has come back
	task automatic drain();
		chars_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (tracker.pending() != 0);
	endtask

	// mostly data records of small size, now and then a long one, plus upper address records
	task automatic send_random_record();
		int len;
		if ($urandom_range(0, 9) < 7) begin
			len = ($urandom_range(0, 39) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
			fill_payload(len);
			send_record(8'(len), 16'($urandom_range(0, 16'hffff)), REC_DATA, 8'h00);
		end else begin
			// the length byte of an upper address record is not looked at
			fill_payload(2);
			send_record(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h02,
				16'($urandom_range(0, 16'hffff)), REC_UPPER, 8'h00);
		end
	endtask

	// every error and end of file halt the parser for good, so one of them closes the run
	task automatic send_terminator();
		logic [7:0] c;
		logic [7:0] t;
		payload_q.delete();
		case ($urandom_range(0, 4))
			0: begin
				// end of file comes straight after the type byte
				send_record(8'h00, 16'($urandom_range(0, 16'hffff)), REC_EOF, 8'h00);
			end
			1: begin
				// missing colon at the start of a record
				do
					c = 8'($urandom_range(0, 255));
				while (record_tracker::is_blank(c) || c == CHAR_COLON);
				send_char(c);
			end
			2: begin
				// bad hex digit somewhere in the length or offset field
				send_char(CHAR_COLON);
				repeat ($urandom_range(0, 5))
					send_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
				do
					c = 8'($urandom_range(0, 255));
				while (record_tracker::is_blank(c) || record_tracker::is_hex(c));
				send_char(c);
			end
			3: begin
				// unknown record type
				do
					t = 8'($urandom_range(0, 255));
				while (t == REC_DATA || t == REC_EOF || t == REC_UPPER);
				send_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hffff)), t,
					8'h00);
			end
			default: begin
				// checksum mismatch on a data record
				fill_payload(int'($urandom_range(0, 8)));
				send_record(8'(payload_q.size()), 16'($urandom_range(0, 16'hffff)), REC_DATA,
					8'($urandom_range(1, 255)));
			end
		endcase
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_in = '0;
		idling = 1'b1;
		chars_sent = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// smallest record: one zero byte at address zero
		payload_q = '{8'h00};
		send_record(8'h01, 16'h0000, REC_DATA, 8'h00);
		// all-ones data byte
		payload_q = '{8'hff, 8'h5a};
		send_record(8'h02, 16'h1234, REC_DATA, 8'h00);
		// top upper address, then a record that runs over the end of the address space
		payload_q = '{8'hff, 8'hff};
		send_record(8'h02, 16'h0000, REC_UPPER, 8'h00);
		payload_q = '{8'ha5, 8'h00, 8'hff};
		send_record(8'h03, 16'hfffe, REC_DATA, 8'h00);
		// empty data record goes straight to its check byte
		payload_q.delete();
		send_record(8'h00, 16'h8000, REC_DATA, 8'h00);
		// upper address record with a length byte it ignores
		payload_q = '{8'h00, 8'h00};
		send_record(8'hff, 16'hffff, REC_UPPER, 8'h00);
		drain();

		chars_sent = 0;
		while (chars_sent < CHAR_TARGET) begin
			if (chars_sent >= CALM_FROM)
				idling = 1'b0;
			send_random_record();
			if (idling && $urandom_range(0, 7) == 0)
				drain();
		end

		send_terminator();
		// halted from here on: random bytes of every value must be swallowed
		repeat (40)
			send_char(8'($urandom_range(0, 255)));
		chars_if.valid <= 1'b0;

		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		tracker.close();
		if (tracker.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
